// ----- sv/g711_pkg.sv -----
// Shared types, mode codes and transcoding tables for the G.711 codec.
`timescale 1ns / 1ps
`default_nettype none
package g711_pkg;

	typedef enum logic [1:0] {
		MODE_PCM_TO_A  = 2'd0,
		MODE_PCM_TO_MU = 2'd1,
		MODE_A_TO_PCM  = 2'd2,
		MODE_MU_TO_PCM = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [15:0] pcm_in;
		logic [7:0]         code_in;
		logic               last_in;
	} sample_t;

	typedef struct packed {
		logic [7:0]         code_out;
		logic signed [15:0] pcm_out;
		logic               last_out;
	} result_t;

	localparam logic [14:0] PCM_MAG_LIMIT = 15'd32635;
	localparam logic [7:0]  A_EVEN_MASK   = 8'hD5;
	localparam logic [6:0]  A_LOW_MASK    = 7'h55;

	localparam logic [7:0] MU_TO_A_ROM [128] = '{
		8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
		8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
		8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
		8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
		8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
		8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
		8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
		8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
		8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
		8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
		8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
		8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
	};

	localparam logic [6:0] A_TO_MU_ROM [128] = '{
		7'd1,   7'd3,   7'd5,   7'd7,   7'd9,   7'd11,  7'd13,  7'd15,
		7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
		7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,  7'd31,
		7'd32,  7'd32,  7'd33,  7'd33,  7'd34,  7'd34,  7'd35,  7'd35,
		7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
		7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd48,  7'd49,  7'd49,
		7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
		7'd58,  7'd59,  7'd60,  7'd61,  7'd62,  7'd63,  7'd64,  7'd64,
		7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd72,
		7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd79,
		7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
		7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
		7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
		7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
		7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
		7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
	};

	function automatic logic [7:0] mu_from_a(input logic [7:0] a);
		logic [6:0] m;
		m = A_TO_MU_ROM[a[6:0] ^ A_LOW_MASK];
		return {a[7], ~m};
	endfunction

	function automatic logic [7:0] a_from_mu(input logic [7:0] u);
		logic [7:0] r;
		logic [6:0] v;
		r = MU_TO_A_ROM[~u[6:0]];
		v = r[6:0] - 7'd1;
		return {u[7], v ^ A_LOW_MASK};
	endfunction

endpackage
`default_nettype wire

// ----- sv/g711_alaw_enc.sv -----
// Linear PCM to A-law encoder: clamp, segment priority search, mantissa pick.
`timescale 1ns / 1ps
`default_nettype none
module g711_alaw_enc (
	input  wire logic signed [15:0] pcm,
	output logic [7:0]              code
);
	import g711_pkg::*;

	logic        sign;
	logic [16:0] mag_full;
	logic [14:0] mag;
	logic [2:0]  seg;
	logic [3:0]  shamt;
	logic [14:0] shifted;
	logic [3:0]  mant;

	assign sign     = pcm[15];
	assign mag_full = sign ? (17'h10000 - {1'b0, pcm}) : {1'b0, pcm};
	assign mag      = (mag_full > {2'b0, PCM_MAG_LIMIT}) ? PCM_MAG_LIMIT : mag_full[14:0];

	always_comb begin
		seg = 3'd0;
		for (int i = 8; i <= 14; i++) begin
			if (mag[i]) begin
				seg = 3'(i - 7);
			end
		end
	end

	assign shamt   = (seg == 3'd0) ? 4'd4 : ({1'b0, seg} + 4'd3);
	assign shifted = mag >> shamt;
	assign mant    = shifted[3:0];
	assign code    = {sign, seg, mant} ^ A_EVEN_MASK;

endmodule
`default_nettype wire

// ----- sv/g711_alaw_dec.sv -----
// A-law to linear PCM expander.
`timescale 1ns / 1ps
`default_nettype none
module g711_alaw_dec (
	input  wire logic [7:0]         code,
	output logic signed [15:0]      pcm
);
	import g711_pkg::*;

	logic [7:0]  a;
	logic [2:0]  seg;
	logic [8:0]  base;
	logic [2:0]  shamt;
	logic [15:0] mag;

	assign a     = {code[7], code[6:0] ^ A_LOW_MASK};
	assign seg   = a[6:4];
	assign base  = {(seg != 3'd0), a[3:0], 4'h8};
	assign shamt = (seg > 3'd1) ? (seg - 3'd1) : 3'd0;
	assign mag   = {7'd0, base} << shamt;
	assign pcm   = a[7] ? $signed(mag) : $signed(16'd0 - mag);

endmodule
`default_nettype wire

// ----- sv/g711_xlat.sv -----
// Mode-selected conversion of one sample to one result.
`timescale 1ns / 1ps
`default_nettype none
module g711_xlat (
	input  wire g711_pkg::mode_t   mode,
	input  wire g711_pkg::sample_t smp,
	output g711_pkg::result_t      res
);
	import g711_pkg::*;

	logic [7:0]         a_enc;
	logic [7:0]         dec_code;
	logic signed [15:0] dec_pcm;

	g711_alaw_enc u_enc (
		.pcm  (smp.pcm_in),
		.code (a_enc)
	);

	assign dec_code = (mode == MODE_MU_TO_PCM) ? a_from_mu(smp.code_in) : smp.code_in;

	g711_alaw_dec u_dec (
		.code (dec_code),
		.pcm  (dec_pcm)
	);

	always_comb begin
		res.last_out = smp.last_in;
		res.code_out = 8'd0;
		res.pcm_out  = 16'sd0;
		case (mode)
			MODE_PCM_TO_A: begin
				res.code_out = a_enc;
			end
			MODE_PCM_TO_MU: begin
				res.code_out = mu_from_a(a_enc);
			end
			MODE_A_TO_PCM, MODE_MU_TO_PCM: begin
				res.pcm_out = dec_pcm;
			end
			default: begin
				res.code_out = 8'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/g711_alaw_ulaw_codec.sv -----
// G.711 A-law / mu-law codec top level: mode register, input and result stages.
// Path: an accepted beat is registered in the input stage, then in the result register, and is then offered.
// Throughput: one beat per cycle while result_ready is high; the input stage and result
// registers each hold a beat, so one new beat is taken while a finished result waits.
// Conversion is one pass of encoder, decoder and table lookups between the two stages.
// Reset: arst_n clears both stage valids and sets the mode to PCM to A-law.
`timescale 1ns / 1ps
`default_nettype none
module g711_alaw_ulaw_codec (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [1:0]        cfg_wr_data,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire g711_pkg::sample_t sample,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output g711_pkg::result_t      result
);
	import g711_pkg::*;

	mode_t   mode_q;
	logic    vld_s1;
	sample_t smp_s1;
	logic    vld_s2;
	result_t res_s2;
	result_t res_d;
	logic    adv_s2;

	assign adv_s2       = !vld_s2 || result_ready;
	assign sample_ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PCM_TO_A;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				vld_s1 <= sample_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			smp_s1 <= sample;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_d;
		end
	end

	g711_xlat u_xlat (
		.mode (mode_q),
		.smp  (smp_s1),
		.res  (res_d)
	);

	assign result_valid = vld_s2;
	assign result       = res_s2;

endmodule
`default_nettype wire

// ----- sv/g711_checker.sv -----
// Port-level checks for the G.711 codec, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module g711_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire g711_pkg::result_t result
);
	import g711_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("input stalled with empty result stage");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready ##1 result_ready |=> result_valid)
		else $error("accepted beat did not reach the result port");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.code_out == 8'd0 || result.pcm_out == 16'sd0))
		else $error("both result fields nonzero");

endmodule

bind g711_alaw_ulaw_codec g711_checker u_g711_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
